@@ hw/rtl/page_write_buffer_manager_macros.svh @@
// assertion macros for the page write buffer manager checker
// depends on a clock named clk and an active-low reset named rst_n in scope
`ifndef PAGE_WRITE_BUFFER_MANAGER_MACROS_SVH
`define PAGE_WRITE_BUFFER_MANAGER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PWBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PWBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pwbm_pkg.sv @@
// shared types and constants for the page write buffer manager
// no dependencies
package pwbm_pkg;

  localparam int ENTRIES = 32;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = 6;
  localparam int ADDR_W  = 32;

  // list codes
  localparam logic [1:0] LIST_FREE    = 2'd0;
  localparam logic [1:0] LIST_BUF     = 2'd1;
  localparam logic [1:0] LIST_WRITING = 2'd2;
  localparam logic [1:0] LIST_UNUSED  = 2'd3;

  // command kinds
  localparam logic [2:0] KIND_PUT     = 3'd0;
  localparam logic [2:0] KIND_LOOKUP  = 3'd1;
  localparam logic [2:0] KIND_TAKE    = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_REMOVE  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_ROOM   = 2'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ADDR_W-1:0] page_address;
    logic [CNT_W-1:0]  batch_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] slot_address;
    logic [CNT_W-1:0]  buffered_count;
    logic [CNT_W-1:0]  freed_count;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic match;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

@@ hw/rtl/pwbm_ctrl.sv @@
// controller state machine for the page write buffer manager
// depends on pwbm_pkg
module pwbm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  pwbm_pkg::dp_status_t   dp_status,
  output pwbm_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_EXEC, S_SEND} state_t;

  state_t state_r;
  state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) begin
        state_nxt = S_MATCH;
      end
      S_MATCH: state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_SEND;
      S_SEND:  if (!out_stall) begin
        state_nxt = dp_status.last ? S_IDLE : S_EXEC;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshake and datapath commands
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SEND);
  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.match = (state_r == S_MATCH);
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

@@ hw/rtl/pwbm_datapath.sv @@
// slot pool, list links, tag match and result register
// depends on pwbm_pkg
module pwbm_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pwbm_pkg::CNT_W-1:0]      cfg_wdata,
  input  pwbm_pkg::in_item_t              in_data,
  input  pwbm_pkg::ctrl_cmd_t             cmd,
  output pwbm_pkg::dp_status_t            dp_status,
  output pwbm_pkg::out_item_t             out_data
);

  logic [pwbm_pkg::ADDR_W-1:0] tag_r   [pwbm_pkg::ENTRIES];
  logic [1:0]                  list_r  [pwbm_pkg::ENTRIES];
  logic [1:0]                  list_nxt[pwbm_pkg::ENTRIES];
  logic [pwbm_pkg::SLOT_W-1:0] next_r  [pwbm_pkg::ENTRIES];
  logic [pwbm_pkg::SLOT_W-1:0] next_nxt[pwbm_pkg::ENTRIES];
  logic [pwbm_pkg::SLOT_W-1:0] prev_r  [pwbm_pkg::ENTRIES];
  logic [pwbm_pkg::SLOT_W-1:0] prev_nxt[pwbm_pkg::ENTRIES];
  logic [pwbm_pkg::SLOT_W-1:0] head_r  [3];
  logic [pwbm_pkg::SLOT_W-1:0] head_nxt[3];
  logic [pwbm_pkg::SLOT_W-1:0] tail_r  [3];
  logic [pwbm_pkg::SLOT_W-1:0] tail_nxt[3];
  logic                        nonempty_r  [3];
  logic                        nonempty_nxt[3];
  logic [pwbm_pkg::CNT_W-1:0]  total_r, total_nxt;
  pwbm_pkg::in_item_t          item_r, item_nxt;
  logic                        found_r, found_nxt;
  logic [pwbm_pkg::SLOT_W-1:0] match_r, match_nxt;
  logic [pwbm_pkg::CNT_W-1:0]  buf_final_r, buf_final_nxt;
  logic [pwbm_pkg::CNT_W-1:0]  k_r, k_nxt;
  pwbm_pkg::out_item_t         out_r, out_nxt;

  logic                        rm_en, ap_en, tag_we, take_ok, init_en;
  logic [1:0]                  rm_list, ap_list;
  logic [pwbm_pkg::SLOT_W-1:0] rm_slot, ap_slot, lp, ln, sel;
  logic [pwbm_pkg::CNT_W-1:0]  n_init;

  assign dp_status.last = out_r.last;
  assign out_data       = out_r;

  // pool size on reset or register write, clamped to between 1 and the pool size
  always_comb begin
    init_en = !rst_n || cfg_we;
    if (!rst_n) begin
      n_init = pwbm_pkg::CNT_W'(pwbm_pkg::ENTRIES);
    end else if (cfg_wdata == '0) begin
      n_init = pwbm_pkg::CNT_W'(1);
    end else if (cfg_wdata > pwbm_pkg::CNT_W'(pwbm_pkg::ENTRIES)) begin
      n_init = pwbm_pkg::CNT_W'(pwbm_pkg::ENTRIES);
    end else begin
      n_init = cfg_wdata;
    end
  end

  // associative match over buffered and writing slots, lowest index wins
  always_comb begin
    found_nxt = found_r;
    match_nxt = match_r;
    buf_final_nxt = buf_final_r;
    if (cmd.match) begin
      found_nxt = 1'b0;
      match_nxt = '0;
      for (int i = pwbm_pkg::ENTRIES - 1; i >= 0; i--) begin
        if ((list_r[i] == pwbm_pkg::LIST_BUF || list_r[i] == pwbm_pkg::LIST_WRITING) &&
            tag_r[i] == item_r.page_address) begin
          found_nxt = 1'b1;
          match_nxt = pwbm_pkg::SLOT_W'(i);
        end
      end
      buf_final_nxt = total_r - item_r.batch_count;
    end
  end

  // one step of the current command
  always_comb begin
    list_nxt     = list_r;
    next_nxt     = next_r;
    prev_nxt     = prev_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    total_nxt    = total_r;
    item_nxt     = item_r;
    k_nxt        = k_r;
    out_nxt      = out_r;
    rm_en   = 1'b0;
    rm_list = pwbm_pkg::LIST_FREE;
    rm_slot = '0;
    ap_en   = 1'b0;
    ap_list = pwbm_pkg::LIST_FREE;
    ap_slot = '0;
    tag_we  = 1'b0;
    take_ok = 1'b0;
    sel     = '0;
    lp      = '0;
    ln      = '0;

    if (cmd.load) begin
      item_nxt = in_data;
      k_nxt    = '0;
    end

    if (cmd.exec) begin
      out_nxt      = '0;
      out_nxt.last = 1'b1;
      case (item_r.kind)
        pwbm_pkg::KIND_PUT: begin
          if (found_r) begin
            rm_en   = 1'b1;
            rm_list = list_r[match_r];
            rm_slot = match_r;
            sel     = match_r;
          end else if (nonempty_r[pwbm_pkg::LIST_FREE]) begin
            rm_en   = 1'b1;
            rm_list = pwbm_pkg::LIST_FREE;
            rm_slot = head_r[pwbm_pkg::LIST_FREE];
            sel     = head_r[pwbm_pkg::LIST_FREE];
            tag_we  = 1'b1;
          end
          if (rm_en) begin
            ap_en   = 1'b1;
            ap_list = pwbm_pkg::LIST_BUF;
            ap_slot = sel;
            out_nxt.slot         = sel;
            out_nxt.slot_address = item_r.page_address;
          end else begin
            out_nxt.status = pwbm_pkg::ST_NO_ROOM;
          end
        end
        pwbm_pkg::KIND_LOOKUP: begin
          if (found_r) begin
            out_nxt.slot         = match_r;
            out_nxt.slot_address = item_r.page_address;
          end else begin
            out_nxt.status = pwbm_pkg::ST_NOT_FOUND;
          end
        end
        pwbm_pkg::KIND_TAKE: begin
          if (k_r == '0 && total_r < item_r.batch_count) begin
            out_nxt.status = pwbm_pkg::ST_NO_ROOM;
          end else if (item_r.batch_count != '0) begin
            sel     = head_r[pwbm_pkg::LIST_BUF];
            rm_en   = 1'b1;
            rm_list = pwbm_pkg::LIST_BUF;
            rm_slot = sel;
            ap_en   = 1'b1;
            ap_list = pwbm_pkg::LIST_WRITING;
            ap_slot = sel;
            take_ok = 1'b1;
            k_nxt   = k_r + 1'b1;
            out_nxt.slot         = sel;
            out_nxt.slot_address = tag_r[sel];
            out_nxt.last         = (k_nxt == item_r.batch_count);
          end
        end
        pwbm_pkg::KIND_RELEASE: begin
          if (nonempty_r[pwbm_pkg::LIST_WRITING]) begin
            sel     = head_r[pwbm_pkg::LIST_WRITING];
            rm_en   = 1'b1;
            rm_list = pwbm_pkg::LIST_WRITING;
            rm_slot = sel;
            ap_en   = 1'b1;
            ap_list = pwbm_pkg::LIST_FREE;
            ap_slot = sel;
            k_nxt   = k_r + 1'b1;
            out_nxt.slot         = sel;
            out_nxt.slot_address = tag_r[sel];
            out_nxt.freed_count  = k_nxt;
            out_nxt.last         = (sel == tail_r[pwbm_pkg::LIST_WRITING]);
          end
        end
        pwbm_pkg::KIND_REMOVE: begin
          if (found_r) begin
            rm_en   = 1'b1;
            rm_list = list_r[match_r];
            rm_slot = match_r;
            ap_en   = 1'b1;
            ap_list = pwbm_pkg::LIST_FREE;
            ap_slot = match_r;
            out_nxt.slot         = match_r;
            out_nxt.slot_address = item_r.page_address;
            out_nxt.freed_count  = pwbm_pkg::CNT_W'(1);
          end else begin
            out_nxt.status = pwbm_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end

    // unlink from a list
    if (rm_en) begin
      lp = prev_nxt[rm_slot];
      ln = next_nxt[rm_slot];
      if (head_nxt[rm_list] == rm_slot && tail_nxt[rm_list] == rm_slot) begin
        nonempty_nxt[rm_list] = 1'b0;
      end else if (head_nxt[rm_list] == rm_slot) begin
        head_nxt[rm_list] = ln;
      end else if (tail_nxt[rm_list] == rm_slot) begin
        tail_nxt[rm_list] = lp;
      end else begin
        next_nxt[lp] = ln;
        prev_nxt[ln] = lp;
      end
      if (rm_list == pwbm_pkg::LIST_BUF) begin
        total_nxt = total_nxt - 1'b1;
      end
    end

    // append at a list tail
    if (ap_en) begin
      if (!nonempty_nxt[ap_list]) begin
        head_nxt[ap_list]     = ap_slot;
        nonempty_nxt[ap_list] = 1'b1;
      end else begin
        next_nxt[tail_nxt[ap_list]] = ap_slot;
        prev_nxt[ap_slot]           = tail_nxt[ap_list];
      end
      tail_nxt[ap_list] = ap_slot;
      list_nxt[ap_slot] = ap_list;
      if (ap_list == pwbm_pkg::LIST_BUF) begin
        total_nxt = total_nxt + 1'b1;
      end
    end

    if (cmd.exec) begin
      out_nxt.buffered_count = take_ok ? buf_final_r : total_nxt;
    end

    // pool initialization: free chain in slot order
    if (init_en) begin
      for (int i = 0; i < pwbm_pkg::ENTRIES; i++) begin
        list_nxt[i] = (pwbm_pkg::CNT_W'(i) < n_init) ? pwbm_pkg::LIST_FREE
                                                     : pwbm_pkg::LIST_UNUSED;
        next_nxt[i] = (pwbm_pkg::CNT_W'(i + 1) < n_init) ? pwbm_pkg::SLOT_W'(i + 1) : '0;
        prev_nxt[i] = (i >= 1 && pwbm_pkg::CNT_W'(i) < n_init) ? pwbm_pkg::SLOT_W'(i - 1)
                                                              : '0;
      end
      for (int j = 0; j < 3; j++) begin
        head_nxt[j]     = '0;
        tail_nxt[j]     = '0;
        nonempty_nxt[j] = 1'b0;
      end
      tail_nxt[pwbm_pkg::LIST_FREE]     = pwbm_pkg::SLOT_W'(n_init - 1'b1);
      nonempty_nxt[pwbm_pkg::LIST_FREE] = 1'b1;
      total_nxt = '0;
    end
  end

  // state registers; reset goes through the initialization path
  always_ff @(posedge clk) begin
    list_r      <= list_nxt;
    next_r      <= next_nxt;
    prev_r      <= prev_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    nonempty_r  <= nonempty_nxt;
    total_r     <= total_nxt;
    item_r      <= item_nxt;
    found_r     <= found_nxt;
    match_r     <= match_nxt;
    buf_final_r <= buf_final_nxt;
    k_r         <= k_nxt;
    out_r       <= out_nxt;
  end

  // tag store, written on a put that takes a free slot
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_r[sel] <= item_r.page_address;
    end
  end

endmodule

@@ hw/rtl/page_write_buffer_manager.sv @@
// Page write buffer manager: keeps a pool of up to 32 page slots on free,
// buffered and writing lists, each tagged with a logical page address. Commands
// are handled one at a time. A command with a single result passes through
// transfer, match, execute and send, and the next input can transfer in the
// cycle after the final result transfer. Each further result of a take batch or
// release adds a list update and an output transfer. The associative tag match
// has its own state. Writing cfg_wdata rebuilds the pool; write only while idle.
// top level: joins the controller and the datapath
// depends on pwbm_pkg, pwbm_ctrl, pwbm_datapath
module page_write_buffer_manager (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pwbm_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pwbm_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [pwbm_pkg::CNT_W-1:0]  cfg_wdata
);

  pwbm_pkg::ctrl_cmd_t  cmd;
  pwbm_pkg::dp_status_t dp_status;

  // sequencing
  pwbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // slot pool and result register
  pwbm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .dp_status (dp_status),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/pwbm_checker.sv @@
// port-level checker for the page write buffer manager, bound to the top level
// depends on pwbm_pkg and page_write_buffer_manager_macros.svh
`include "page_write_buffer_manager_macros.svh"

module pwbm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pwbm_pkg::out_item_t out_data
);

  // no new command while a result is pending
  `PWBM_ASSERT_NOW(a_busy_while_result, out_valid, in_stall, "input taken with result pending")

  // a command transfer is followed by the match cycle
  `PWBM_ASSERT_NEXT(a_accept_then_match, in_valid && !in_stall, !out_valid && in_stall, "no match cycle after transfer")

  // the final result returns the block to idle
  `PWBM_ASSERT_NEXT(a_last_then_idle, out_valid && !out_stall && out_data.last, !out_valid && !in_stall, "not idle after final result")

  // a further result needs a list update cycle first
  `PWBM_ASSERT_NEXT(a_more_then_exec, out_valid && !out_stall && !out_data.last, !out_valid && in_stall, "no update cycle between results")

  // status is one of the defined codes
  `PWBM_ASSERT_NOW(a_status_code, out_valid, out_data.status <= pwbm_pkg::ST_NO_ROOM, "undefined status code")

endmodule

bind page_write_buffer_manager pwbm_checker u_pwbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/page_write_buffer_manager_tb.sv @@
// testbench for the page write buffer manager: slot pool scoreboard and drivers
// depends on pwbm_pkg and page_write_buffer_manager
module page_write_buffer_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwbm_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = KIND_REMOVE + 3'd1;

  // slot pool model with the queue of expected results
  class slot_pool_board;
    logic [ADDR_W-1:0] tag [ENTRIES];
    logic [1:0]        owner [ENTRIES];
    logic [SLOT_W-1:0] nxt [ENTRIES];
    logic [SLOT_W-1:0] prv [ENTRIES];
    logic [SLOT_W-1:0] head [3];
    logic [SLOT_W-1:0] tail [3];
    bit                filled [3];
    logic [CNT_W-1:0]  buf_total;
    out_item_t         pending_results [$];

    function new();
      configure(6'd32);
    endfunction

    function void configure(logic [CNT_W-1:0] value);
      int n;
      n = value;
      if (n == 0) n = 1;
      if (n > ENTRIES) n = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
        tag[i] = '0; nxt[i] = '0; prv[i] = '0; owner[i] = LIST_UNUSED;
      end
      for (int l = 0; l < 3; l++) begin
        head[l] = '0; tail[l] = '0; filled[l] = 0;
      end
      for (int i = 0; i < n; i++) attach(LIST_FREE, i);
      buf_total = '0;
    endfunction

    function void detach(logic [1:0] l, int s);
      if (head[l] == s && tail[l] == s) filled[l] = 0;
      else if (head[l] == s) head[l] = nxt[s];
      else if (tail[l] == s) tail[l] = prv[s];
      else begin
        nxt[prv[s]] = nxt[s];
        prv[nxt[s]] = prv[s];
      end
    endfunction

    function void attach(logic [1:0] l, int s);
      if (!filled[l]) begin
        head[l] = SLOT_W'(s);
        filled[l] = 1;
      end else begin
        nxt[tail[l]] = SLOT_W'(s);
        prv[s] = tail[l];
      end
      tail[l] = SLOT_W'(s);
      owner[s] = l;
    endfunction

    function int find_page(logic [ADDR_W-1:0] a);
      for (int i = 0; i < ENTRIES; i++)
        if ((owner[i] == LIST_BUF || owner[i] == LIST_WRITING) && tag[i] == a) return i;
      return -1;
    endfunction

    function void unlink_used(int s);
      if (owner[s] == LIST_BUF) begin
        detach(LIST_BUF, s);
        buf_total = buf_total - 1'b1;
      end else detach(LIST_WRITING, s);
    endfunction

    function out_item_t mk(logic [1:0] st, int s, logic [ADDR_W-1:0] a, int freed);
      out_item_t o;
      o = '0;
      o.status = st;
      o.slot = SLOT_W'(s);
      o.slot_address = a;
      o.freed_count = CNT_W'(freed);
      return o;
    endfunction

    // predict every result that one accepted command causes
    function void note_input(in_item_t it);
      out_item_t r [$];
      int s;
      int freed;
      s = -1;
      freed = 0;
      case (it.kind)
        KIND_PUT: begin
          s = find_page(it.page_address);
          if (s >= 0) unlink_used(s);
          else if (filled[LIST_FREE]) begin
            s = head[LIST_FREE];
            detach(LIST_FREE, s);
            tag[s] = it.page_address;
          end
          if (s >= 0) begin
            attach(LIST_BUF, s);
            buf_total = buf_total + 1'b1;
            r.push_back(mk(ST_OK, s, it.page_address, 0));
          end else r.push_back(mk(ST_NO_ROOM, 0, '0, 0));
        end
        KIND_LOOKUP: begin
          s = find_page(it.page_address);
          if (s >= 0) r.push_back(mk(ST_OK, s, it.page_address, 0));
          else r.push_back(mk(ST_NOT_FOUND, 0, '0, 0));
        end
        KIND_TAKE: begin
          if (buf_total < it.batch_count) r.push_back(mk(ST_NO_ROOM, 0, '0, 0));
          else if (it.batch_count == 0) r.push_back(mk(ST_OK, 0, '0, 0));
          else
            for (int i = 0; i < it.batch_count && filled[LIST_BUF]; i++) begin
              s = head[LIST_BUF];
              unlink_used(s);
              attach(LIST_WRITING, s);
              r.push_back(mk(ST_OK, s, tag[s], 0));
            end
        end
        KIND_RELEASE: begin
          while (filled[LIST_WRITING] && r.size() < ENTRIES) begin
            s = head[LIST_WRITING];
            detach(LIST_WRITING, s);
            attach(LIST_FREE, s);
            freed++;
            r.push_back(mk(ST_OK, s, tag[s], freed));
          end
          if (r.size() == 0) r.push_back(mk(ST_OK, 0, '0, 0));
        end
        KIND_REMOVE: begin
          s = find_page(it.page_address);
          if (s >= 0) begin
            unlink_used(s);
            attach(LIST_FREE, s);
            r.push_back(mk(ST_OK, s, it.page_address, 1));
          end else r.push_back(mk(ST_NOT_FOUND, 0, '0, 0));
        end
        default: r.push_back(mk(ST_OK, 0, '0, 0));
      endcase
      foreach (r[i]) begin
        r[i].buffered_count = buf_total;
        r[i].last = (i == r.size() - 1);
        pending_results.push_back(r[i]);
      end
    endfunction

    // compare one result with the oldest expectation; empty string when it matches
    function string check_result(out_item_t got);
      out_item_t e;
      string why;
      if (pending_results.size() == 0) return "result with nothing expected";
      e = pending_results.pop_front();
      why = "";
      if (got.status !== e.status)
        why = {why, $sformatf(" status %0d/%0d", got.status, e.status)};
      if (got.slot !== e.slot) why = {why, $sformatf(" slot %0d/%0d", got.slot, e.slot)};
      if (got.slot_address !== e.slot_address)
        why = {why, $sformatf(" addr %h/%h", got.slot_address, e.slot_address)};
      if (got.buffered_count !== e.buffered_count)
        why = {why, $sformatf(" buffered %0d/%0d", got.buffered_count, e.buffered_count)};
      if (got.freed_count !== e.freed_count)
        why = {why, $sformatf(" freed %0d/%0d", got.freed_count, e.freed_count)};
      if (got.last !== e.last) why = {why, $sformatf(" last %0d/%0d", got.last, e.last)};
      return why;
    endfunction
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 0;
  out_item_t        out_data;
  logic             cfg_we = 0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  slot_pool_board   pool_board;
  int               mismatches = 0;
  int               commands_sent = 0;
  int               results_seen = 0;
  int               cfg_writes = 0;
  bit               calm = 0;
  logic [ADDR_W-1:0] addr_set [8];

  page_write_buffer_manager DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #5ms;
    $display("page_write_buffer_manager verification failed");
    $finish;
  end

  task report_mismatch(input string why);
    mismatches++;
    $display("mismatch at %0t:%s", $realtime, why);
  endtask

  // receiver stalls at random outside the calm stretch
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 16);

  // result transfer check, sampled mid-cycle
  initial forever begin
    string why;
    @(negedge clk);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      why = pool_board.check_result(out_data);
      if (why != "") report_mismatch(why);
    end
  end

  // valid stays up after a transfer until the next idle or drain drops it
  task send_item(input in_item_t it);
    bit taken;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    pool_board.note_input(it);
    commands_sent++;
  endtask

  task send_cmd(input logic [2:0] k, input logic [ADDR_W-1:0] a, input logic [CNT_W-1:0] b);
    in_item_t it;
    it.kind = k;
    it.page_address = a;
    it.batch_count = b;
    send_item(it);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (pool_board.pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task write_slots(input logic [CNT_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_board.configure(v);
    cfg_writes++;
  endtask

  function logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(9) == 0) return $urandom;
    return addr_set[$urandom_range(7)];
  endfunction

  // mostly puts and takes so that lists fill, drain and wrap
  task random_cmd();
    int roll;
    logic [CNT_W-1:0] b;
    roll = $urandom_range(99);
    if ($urandom_range(9) == 0) b = CNT_W'($urandom_range(63));
    else b = CNT_W'($urandom_range(6));
    if (roll < 38) send_cmd(KIND_PUT, pick_addr(), CNT_W'($urandom));
    else if (roll < 52) send_cmd(KIND_LOOKUP, pick_addr(), CNT_W'($urandom));
    else if (roll < 68) send_cmd(KIND_TAKE, $urandom, b);
    else if (roll < 78) send_cmd(KIND_RELEASE, $urandom, CNT_W'($urandom));
    else if (roll < 95) send_cmd(KIND_REMOVE, pick_addr(), CNT_W'($urandom));
    else send_cmd(3'(KIND_SPARE_LO + $urandom_range(2)), $urandom, CNT_W'($urandom));
  endtask

  initial begin
    logic [CNT_W-1:0] settings [6];
    pool_board = new();
    settings[0] = 6'd1;
    settings[1] = 6'd0;
    settings[2] = 6'd63;
    settings[3] = 6'd32;
    settings[4] = 6'd3;
    settings[5] = CNT_W'($urandom_range(1, 63));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: address extremes, every kind, batch edge cases, empty release
    send_cmd(KIND_PUT, 32'h0000_0000, 6'd0);
    send_cmd(KIND_PUT, 32'hFFFF_FFFF, 6'd63);
    send_cmd(KIND_PUT, 32'h0000_0000, 6'd0);
    send_cmd(KIND_LOOKUP, 32'h0000_0000, 6'd0);
    send_cmd(KIND_LOOKUP, 32'h1234_5678, 6'd0);
    send_cmd(KIND_TAKE, 32'h0, 6'd0);
    send_cmd(KIND_TAKE, 32'h0, 6'd63);
    send_cmd(KIND_TAKE, 32'h0, 6'd3);
    send_cmd(KIND_TAKE, 32'h0, 6'd2);
    send_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    send_cmd(KIND_PUT, 32'hFFFF_FFFF, 6'd0);
    send_cmd(KIND_TAKE, 32'h0, 6'd1);
    send_cmd(KIND_RELEASE, 32'h0, 6'd0);
    send_cmd(KIND_RELEASE, 32'h0, 6'd0);
    send_cmd(KIND_PUT, 32'hA5A5_5A5A, 6'd0);
    send_cmd(KIND_REMOVE, 32'hA5A5_5A5A, 6'd0);
    send_cmd(KIND_REMOVE, 32'hA5A5_5A5A, 6'd0);
    for (int k = 0; k < 3; k++) send_cmd(3'(KIND_SPARE_LO + k), 32'hFFFF_FFFF, 6'd63);

    // random phases over several pool sizes
    foreach (settings[p]) begin
      write_slots(settings[p]);
      foreach (addr_set[i]) addr_set[i] = $urandom;
      addr_set[0] = 32'h0000_0000;
      addr_set[1] = 32'hFFFF_FFFF;
      calm = (p == 2);
      for (int n = 0; n < 80; n++) begin
        if (n == 40) wait_drained();
        random_cmd();
      end
      // drain a phase with one full batch take and release
      send_cmd(KIND_TAKE, 32'h0, pool_board.buf_total);
      send_cmd(KIND_RELEASE, 32'h0, 6'd0);
    end
    calm = 0;

    wait_drained();
    repeat (40) @(posedge clk);
    $display("ran %0d commands over %0d pool sizes, %0d results checked",
             commands_sent, cfg_writes, results_seen);
    if (mismatches == 0 && pool_board.pending_results.size() == 0)
      $display("page_write_buffer_manager verification clean");
    else
      $display("page_write_buffer_manager verification failed");
    $finish;
  end
endmodule
